// File: rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros for the rational arithmetic unit RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define RAU_ASSERT_NOW(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define RAU_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

// File: rtl/rau_pkg.sv
// ---------------------------------------------------------------------------
// rau_pkg
// Shared types and constants of the rational arithmetic unit.
// ---------------------------------------------------------------------------
`default_nettype none

package rau_pkg;

    localparam int RAU_WORD_WIDTH = 32;
    localparam int RAU_NUM_W      = 32;
    localparam int RAU_DEN_W      = 31;
    localparam int RAU_ACT_W      = 2;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } rau_op_t;

    typedef enum logic [1:0] {
        P_ANBD = 2'd0,
        P_ADBN = 2'd1,
        P_ADBD = 2'd2,
        P_ANBN = 2'd3
    } rau_prod_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PRE_NEG,
        S_MUL_LOAD,
        S_MUL,
        S_MUL_END,
        S_B_CHK,
        S_B_NEGN,
        S_B_NEGD,
        S_B_ABS,
        S_B_TEST,
        S_GCD2,
        S_GCD,
        S_DIV,
        S_B_SIGN,
        S_DONE
    } rau_state_t;

    typedef struct packed {
        logic ready;
        logic done;
    } rau_status_t;

endpackage

`default_nettype wire

// File: rtl/rational_arithmetic_unit.sv
// ---------------------------------------------------------------------------
// rational_arithmetic_unit
// Add, subtract, multiply or divide two fractions and reduce the result.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel s_*: one item holds two fractions a_num/a_den, b_num/b_den
//   in s_tdata and the operation (add, subtract, multiply, divide) in s_tuser.
//   Output channel m_*: one item per input, the reduced result_num/result_den.
//   Cross products wrap at WORD_WIDTH bits; the result then has a zero
//   denominator replaced by 1, a negative denominator's sign moved to the
//   numerator, and is divided by the gcd (zero numerators stay unreduced).
// Sequencing:
//   One item is worked at a time on a single shared adder. Each product is a
//   shift-add. A reduction is skipped for a zero or wrapped magnitude; else it
//   strips common twos, runs a data-dependent binary gcd and then divides
//   numerator and denominator by the gcd in two restoring divisions.
//   Multiply: 2 products + 1 reduction; add 3 + 1; divide 2 + 2; subtract 3 + 2.
// Reset: rst_n clears the sequencer and the output valid; no item is held.
// Stall: a finished result waits in the output register; the sequencer may
//   take the next item meanwhile and holds its result until the register frees.
// ---------------------------------------------------------------------------
`default_nettype none

module rational_arithmetic_unit
    import rau_pkg::*;
#(
    parameter int WORD_WIDTH = RAU_WORD_WIDTH
)
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // a_num[31:0], a_den[62:32], b_num[94:63], b_den[125:95], zero pad
    input  wire logic [127:0] s_tdata,
    // action[1:0]
    input  wire logic [1:0]   s_tuser,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // result_num[31:0], result_den[62:32], zero pad
    output logic [63:0]       m_tdata
);

    localparam int W = WORD_WIDTH;

    rau_status_t  status;
    logic         start;
    logic         take;
    logic [W-1:0] res_num, res_den;
    logic [W+31:0] an_ext, bn_ext, ad_ext, bd_ext;
    logic [W+31:0] rn_ext, rd_ext;

    logic                 out_valid_reg, out_valid_next;
    logic [RAU_NUM_W-1:0] num_reg, num_next;
    logic [RAU_DEN_W-1:0] den_reg, den_next;

    // Sign-extend numerators, zero-extend denominators, wrap to W bits
    assign an_ext = {{W{s_tdata[31]}}, s_tdata[31:0]};
    assign ad_ext = {{(W+1){1'b0}}, s_tdata[62:32]};
    assign bn_ext = {{W{s_tdata[94]}}, s_tdata[94:63]};
    assign bd_ext = {{(W+1){1'b0}}, s_tdata[125:95]};

    assign start = s_tvalid && s_tready;
    assign take  = status.done && (!out_valid_reg || m_tready);

    rau_core #(.W(W)) u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .action  (rau_op_t'(s_tuser)),
        .a_num   (an_ext[W-1:0]),
        .a_den   (ad_ext[W-1:0]),
        .b_num   (bn_ext[W-1:0]),
        .b_den   (bd_ext[W-1:0]),
        .take    (take),
        .status  (status),
        .res_num (res_num),
        .res_den (res_den)
    );

    // Result words sign-extended, then cut to field widths
    assign rn_ext = {{32{res_num[W-1]}}, res_num};
    assign rd_ext = {{32{res_den[W-1]}}, res_den};

    always_comb
    begin
        out_valid_next = out_valid_reg;
        num_next       = num_reg;
        den_next       = den_reg;
        if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        if (take)
        begin
            // load the finished item into the output register
            out_valid_next = 1'b1;
            num_next       = rn_ext[RAU_NUM_W-1:0];
            den_next       = rd_ext[RAU_DEN_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        den_reg <= den_next;
    end

    assign s_tready = status.ready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, den_reg, num_reg};

endmodule

`default_nettype wire

// File: rtl/rau_alu.sv
// ---------------------------------------------------------------------------
// rau_alu
// Shared add/subtract unit; carry out doubles as the a >= b compare.
// ---------------------------------------------------------------------------
`default_nettype none

module rau_alu
    import rau_pkg::*;
#(
    parameter int W = RAU_WORD_WIDTH
)
(
    input  wire logic [W-1:0] op_a,
    input  wire logic [W-1:0] op_b,
    input  wire logic         sub,
    output logic      [W-1:0] sum,
    output logic              carry
);

    logic [W:0] full;

    assign full  = {1'b0, op_a} + {1'b0, (sub ? ~op_b : op_b)} + {{W{1'b0}}, sub};
    assign sum   = full[W-1:0];
    assign carry = full[W];

endmodule

`default_nettype wire

// File: rtl/rau_core.sv
// ---------------------------------------------------------------------------
// rau_core
// Sequencer: shift-add products, binary gcd and restoring division on one ALU.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module rau_core
    import rau_pkg::*;
#(
    parameter int W = RAU_WORD_WIDTH
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire rau_op_t     action,
    input  wire logic [W-1:0] a_num,
    input  wire logic [W-1:0] a_den,
    input  wire logic [W-1:0] b_num,
    input  wire logic [W-1:0] b_den,
    input  wire logic        take,
    output rau_status_t      status,
    output logic [W-1:0]     res_num,
    output logic [W-1:0]     res_den
);

    localparam int CW = $clog2(W + 1);
    localparam int KW = $clog2(W);

    rau_state_t state_reg, state_next;
    rau_op_t    op_reg, op_next;
    rau_prod_t  sel_reg, sel_next;
    logic       post_reg, post_next;
    logic       s1_reg, s1_next;
    logic       dsel_reg, dsel_next;
    logic [W-1:0] an_reg, an_next, ad_reg, ad_next, bn_reg, bn_next, bd_reg, bd_next;
    logic [W-1:0] x_reg, x_next, y_reg, y_next, gx_reg, gx_next, gy_reg, gy_next;
    logic [W-1:0] acc_reg, acc_next, mcand_reg, mcand_next, mplier_reg, mplier_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [KW-1:0] k_reg, k_next;

    logic [W-1:0] alu_a, alu_b, alu_sum;
    logic         alu_sub, alu_carry;
    logic         dbit;
    logic [W-1:0] sval;

    rau_alu #(.W(W)) u_alu (
        .op_a  (alu_a),
        .op_b  (alu_b),
        .sub   (alu_sub),
        .sum   (alu_sum),
        .carry (alu_carry)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        sel_reg    <= sel_next;
        post_reg   <= post_next;
        s1_reg     <= s1_next;
        dsel_reg   <= dsel_next;
        an_reg     <= an_next;
        ad_reg     <= ad_next;
        bn_reg     <= bn_next;
        bd_reg     <= bd_next;
        x_reg      <= x_next;
        y_reg      <= y_next;
        gx_reg     <= gx_next;
        gy_reg     <= gy_next;
        acc_reg    <= acc_next;
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
        cnt_reg    <= cnt_next;
        k_reg      <= k_next;
    end

    // ALU operand selection
    always_comb
    begin
        alu_a   = '0;
        alu_b   = '0;
        alu_sub = 1'b1;
        dbit    = dsel_reg ? y_reg[W-1] : x_reg[W-1];
        unique case (state_reg)
            S_PRE_NEG: alu_b = bn_reg;
            S_B_NEGN:  alu_b = x_reg;
            S_B_NEGD:  alu_b = y_reg;
            S_B_ABS:   alu_b = x_reg;
            S_B_SIGN:  alu_b = x_reg;
            S_GCD:
            begin
                alu_a = gx_reg;
                alu_b = gy_reg;
            end
            S_DIV:
            begin
                alu_a = {gy_reg[W-2:0], dbit};
                alu_b = gx_reg;
            end
            S_MUL:
            begin
                alu_a   = acc_reg;
                alu_b   = mcand_reg;
                alu_sub = 1'b0;
            end
            default:
            begin
                alu_a = '0;
            end
        endcase
    end

    assign sval = s1_reg ? alu_sum : x_reg;

    always_comb
    begin
        state_next  = state_reg;
        op_next     = op_reg;
        sel_next    = sel_reg;
        post_next   = post_reg;
        s1_next     = s1_reg;
        dsel_next   = dsel_reg;
        an_next     = an_reg;
        ad_next     = ad_reg;
        bn_next     = bn_reg;
        bd_next     = bd_reg;
        x_next      = x_reg;
        y_next      = y_reg;
        gx_next     = gx_reg;
        gy_next     = gy_reg;
        acc_next    = acc_reg;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        cnt_next    = cnt_reg;
        k_next      = k_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    op_next   = action;
                    post_next = 1'b0;
                    an_next   = a_num;
                    ad_next   = a_den;
                    bn_next   = b_num;
                    bd_next   = b_den;
                    acc_next  = '0;
                    unique case (action)
                        OP_ADD:
                        begin
                            sel_next   = P_ANBD;
                            state_next = S_MUL_LOAD;
                        end
                        OP_MUL:
                        begin
                            sel_next   = P_ANBN;
                            state_next = S_MUL_LOAD;
                        end
                        OP_SUB:
                        begin
                            state_next = S_PRE_NEG;
                        end
                        default:
                        begin
                            // reciprocal of b: swap numerator and denominator
                            x_next     = b_den;
                            y_next     = b_num;
                            state_next = S_B_CHK;
                        end
                    endcase
                end
            end
            S_PRE_NEG:
            begin
                x_next     = alu_sum;
                y_next     = bd_reg;
                state_next = S_B_CHK;
            end
            S_MUL_LOAD:
            begin
                unique case (sel_reg)
                    P_ANBD:
                    begin
                        mcand_next  = an_reg;
                        mplier_next = bd_reg;
                    end
                    P_ADBN:
                    begin
                        mcand_next  = ad_reg;
                        mplier_next = bn_reg;
                    end
                    P_ADBD:
                    begin
                        mcand_next  = ad_reg;
                        mplier_next = bd_reg;
                    end
                    default:
                    begin
                        mcand_next  = an_reg;
                        mplier_next = bn_reg;
                    end
                endcase
                cnt_next   = CW'(W);
                state_next = S_MUL;
            end
            S_MUL:
            begin
                if (mplier_reg[0])
                begin
                    acc_next = alu_sum;
                end
                mcand_next  = {mcand_reg[W-2:0], 1'b0};
                mplier_next = {1'b0, mplier_reg[W-1:1]};
                cnt_next    = cnt_reg - CW'(1);
                if (cnt_reg == CW'(1))
                begin
                    state_next = S_MUL_END;
                end
            end
            S_MUL_END:
            begin
                unique case (sel_reg)
                    P_ANBD:
                    begin
                        // keep the sum running into the second cross product
                        sel_next   = P_ADBN;
                        state_next = S_MUL_LOAD;
                    end
                    P_ADBD:
                    begin
                        y_next     = acc_reg;
                        post_next  = 1'b1;
                        state_next = S_B_CHK;
                    end
                    default:
                    begin
                        x_next     = acc_reg;
                        acc_next   = '0;
                        sel_next   = P_ADBD;
                        state_next = S_MUL_LOAD;
                    end
                endcase
            end
            S_B_CHK:
            begin
                if (y_reg == '0)
                begin
                    y_next     = {{(W-1){1'b0}}, 1'b1};
                    state_next = S_B_ABS;
                end
                else if (y_reg[W-1])
                begin
                    state_next = S_B_NEGN;
                end
                else
                begin
                    state_next = S_B_ABS;
                end
            end
            S_B_NEGN:
            begin
                x_next     = alu_sum;
                state_next = S_B_NEGD;
            end
            S_B_NEGD:
            begin
                y_next     = alu_sum;
                state_next = S_B_ABS;
            end
            S_B_ABS:
            begin
                s1_next = x_reg[W-1];
                if (x_reg[W-1])
                begin
                    x_next = alu_sum;
                end
                state_next = S_B_TEST;
            end
            S_B_TEST:
            begin
                // zero or wrapped magnitudes stay unreduced
                if ((x_reg == '0) || x_reg[W-1] || y_reg[W-1])
                begin
                    state_next = S_B_SIGN;
                end
                else
                begin
                    gx_next    = x_reg;
                    gy_next    = y_reg;
                    k_next     = '0;
                    state_next = S_GCD2;
                end
            end
            S_GCD2:
            begin
                if (!gx_reg[0] && !gy_reg[0])
                begin
                    gx_next = {1'b0, gx_reg[W-1:1]};
                    gy_next = {1'b0, gy_reg[W-1:1]};
                    k_next  = k_reg + KW'(1);
                end
                else
                begin
                    state_next = S_GCD;
                end
            end
            S_GCD:
            begin
                priority if (!gx_reg[0])
                begin
                    gx_next = {1'b0, gx_reg[W-1:1]};
                end
                else if (!gy_reg[0])
                begin
                    gy_next = {1'b0, gy_reg[W-1:1]};
                end
                else if (alu_sum == '0)
                begin
                    // gcd found: restore the common twos, start dividing
                    gx_next    = gx_reg << k_reg;
                    gy_next    = '0;
                    cnt_next   = CW'(W);
                    dsel_next  = 1'b0;
                    state_next = S_DIV;
                end
                else if (!alu_carry)
                begin
                    gx_next = gy_reg;
                    gy_next = gx_reg;
                end
                else
                begin
                    gx_next = alu_sum;
                end
            end
            S_DIV:
            begin
                gy_next = alu_carry ? alu_sum : {gy_reg[W-2:0], dbit};
                if (dsel_reg)
                begin
                    y_next = {y_reg[W-2:0], alu_carry};
                end
                else
                begin
                    x_next = {x_reg[W-2:0], alu_carry};
                end
                cnt_next = cnt_reg - CW'(1);
                if (cnt_reg == CW'(1))
                begin
                    if (!dsel_reg)
                    begin
                        dsel_next = 1'b1;
                        gy_next   = '0;
                        cnt_next  = CW'(W);
                    end
                    else
                    begin
                        state_next = S_B_SIGN;
                    end
                end
            end
            S_B_SIGN:
            begin
                x_next = sval;
                if (post_reg)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    bn_next    = sval;
                    bd_next    = y_reg;
                    acc_next   = '0;
                    sel_next   = (op_reg == OP_SUB) ? P_ANBD : P_ANBN;
                    state_next = S_MUL_LOAD;
                end
            end
            S_DONE:
            begin
                if (take)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign status.ready = (state_reg == S_IDLE);
    assign status.done  = (state_reg == S_DONE);
    assign res_num      = x_reg;
    assign res_den      = y_reg;

    `RAU_ASSERT_NOW(a_gcd_nonzero, state_reg == S_GCD, (gx_reg != '0) && (gy_reg != '0),
        "gcd operand reached zero")
    `RAU_ASSERT_NOW(a_div_rem, state_reg == S_DIV, gy_reg < gx_reg,
        "division remainder not below divisor")
    `RAU_ASSERT_NEXT(a_start_leaves_idle, (state_reg == S_IDLE) && start,
        state_reg != S_IDLE, "accepted item did not start the sequencer")

endmodule

`default_nettype wire

// File: bench/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for rational_arithmetic_unit: random and corner-case
// fraction pairs go in through the s_* stream, and a bit-accurate predictor
// of the reduced result checks every item that leaves through m_*.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
    import rau_pkg::*;

    typedef struct {
        rau_op_t     op;
        logic [31:0] an;
        logic [30:0] ad;
        logic [31:0] bn;
        logic [30:0] bd;
    } frac_pair_t;

    typedef struct {
        logic [31:0] num;
        logic [31:0] den;
    } frac_t;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [127:0] s_tdata = '0;
    logic [1:0]   s_tuser = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [63:0]  m_tdata;

    frac_pair_t pending_pairs[$];
    frac_t      expected_fracs[$];
    logic       in_fire = 1'b0;
    int         tx_idle_pct = 0;
    int         rx_idle_pct = 0;
    int         hold_req = 0;
    int         hold_seen = 0;
    int         hold_left = 0;
    int         fail_count = 0;

    rational_arithmetic_unit u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // 4 ns clock
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic logic [31:0] gcd_word(logic [31:0] x, logic [31:0] y);
        logic [31:0] t;
        while (y != 0)
        begin
            t = x % y;
            x = y;
            y = t;
        end
        return x;
    endfunction

    // Normalize a wrapped fraction: zero denominator becomes 1, the sign of
    // the denominator moves up, then divide out the gcd of the magnitudes.
    // A magnitude that wraps to the most negative word blocks the reduction.
    function automatic frac_t reduce_frac(logic [31:0] num, logic [31:0] den);
        frac_t       r;
        logic        n_neg;
        logic        d_neg;
        logic [31:0] m;
        logic [31:0] d;
        logic [31:0] g;
        if (den == 0)
            den = 32'd1;
        if (den[31])
        begin
            num = -num;
            den = -den;
        end
        n_neg = num[31];
        m     = n_neg ? -num : num;
        d_neg = den[31];
        d     = d_neg ? -den : den;
        if (m != 0 && d != 0 && !m[31] && !d[31])
        begin
            g = gcd_word(m, d);
            m = m / g;
            d = d / g;
        end
        r.num = n_neg ? -m : m;
        r.den = d_neg ? -d : d;
        return r;
    endfunction

    function automatic frac_t rational_result(frac_pair_t p);
        frac_t a;
        frac_t b;
        a.num = p.an;
        a.den = {1'b0, p.ad};
        b.num = p.bn;
        b.den = {1'b0, p.bd};
        case (p.op)
            OP_SUB:  b = reduce_frac(-p.bn, {1'b0, p.bd});
            OP_DIV:  b = reduce_frac({1'b0, p.bd}, p.bn);
            default: ;
        endcase
        if (p.op == OP_ADD || p.op == OP_SUB)
            return reduce_frac(a.num * b.den + a.den * b.num, a.den * b.den);
        return reduce_frac(a.num * b.num, a.den * b.den);
    endfunction

    // ------------------------------------------------------------------
    // Driver: advance on acceptance, hold an offered item until taken
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin : drive_s
        logic       hold;
        frac_pair_t p;
        hold = s_tvalid && !in_fire;
        if (in_fire)
            void'(pending_pairs.pop_front());
        if (!hold)
        begin
            if (rst_n && pending_pairs.size() > 0 && $urandom_range(99) >= tx_idle_pct)
            begin
                p = pending_pairs[0];
                s_tvalid <= 1'b1;
                s_tdata  <= {2'b00, p.bd, p.bn, p.ad, p.an};
                s_tuser  <= p.op;
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // Receiver: random stalls, plus a long hold-off on request
    always @(negedge clk)
    begin : drive_m
        if (hold_seen != hold_req)
        begin
            hold_seen = hold_req;
            hold_left = 2000;
        end
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            m_tready <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(99) >= rx_idle_pct);
    end

    // ------------------------------------------------------------------
    // Monitor: predict on input acceptance, compare on output acceptance
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : watch
        frac_pair_t p;
        frac_t      e;
        in_fire <= s_tvalid && s_tready;
        if (s_tvalid && s_tready)
        begin
            p.an = s_tdata[31:0];
            p.ad = s_tdata[62:32];
            p.bn = s_tdata[94:63];
            p.bd = s_tdata[125:95];
            p.op = rau_op_t'(s_tuser);
            expected_fracs.push_back(rational_result(p));
        end
        if (m_tvalid && m_tready)
        begin
            if (expected_fracs.size() == 0)
            begin
                $display("%0t: unexpected result num=%h den=%h", $time,
                         m_tdata[31:0], m_tdata[62:32]);
                fail_count = fail_count + 1;
            end
            else
            begin
                e = expected_fracs.pop_front();
                if (m_tdata[31:0] !== e.num)
                begin
                    $display("%0t: result_num expected %h actual %h", $time,
                             e.num, m_tdata[31:0]);
                    fail_count = fail_count + 1;
                end
                if (m_tdata[62:32] !== e.den[30:0])
                begin
                    $display("%0t: result_den expected %h actual %h", $time,
                             e.den[30:0], m_tdata[62:32]);
                    fail_count = fail_count + 1;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    function automatic logic [31:0] pick_num();
        case ($urandom_range(9))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'd0;
            3, 4:    return $urandom;
            default: return $urandom_range(40) - 20;
        endcase
    endfunction

    function automatic logic [30:0] pick_den();
        case ($urandom_range(11))
            0:       return 31'd0;
            1:       return 31'h7FFF_FFFF;
            2:       return 31'h4000_0000;
            3, 4:    return 31'($urandom);
            default: return 31'($urandom_range(24, 1));
        endcase
    endfunction

    task automatic queue_pair(rau_op_t op, logic [31:0] an, logic [30:0] ad,
                              logic [31:0] bn, logic [30:0] bd);
        frac_pair_t p;
        p.op = op;
        p.an = an;
        p.ad = ad;
        p.bn = bn;
        p.bd = bd;
        pending_pairs.push_back(p);
    endtask

    task automatic queue_random(int count);
        repeat (count)
            queue_pair(rau_op_t'($urandom_range(3)), pick_num(), pick_den(),
                       pick_num(), pick_den());
    endtask

    // Wait until every queued pair is sent and every expected result has come back
    task automatic drain();
        while (pending_pairs.size() > 0 || expected_fracs.size() > 0)
            @(posedge clk);
        repeat (400) @(posedge clk);
    endtask

    initial
    begin
        repeat (8) @(negedge clk);
        rst_n = 1'b1;

        // every operation on plain values
        queue_pair(OP_ADD, 32'd1, 31'd2, 32'd1, 31'd3);
        queue_pair(OP_SUB, 32'd1, 31'd2, 32'd1, 31'd3);
        queue_pair(OP_MUL, 32'd2, 31'd3, 32'd9, 31'd4);
        queue_pair(OP_DIV, 32'd2, 31'd3, 32'd4, 31'd9);
        queue_pair(OP_ADD, -32'sd5, 31'd6, 32'd7, 31'd6);
        // zero numerator stays unreduced
        queue_pair(OP_MUL, 32'd0, 31'd6, 32'd3, 31'd4);
        queue_pair(OP_SUB, 32'd3, 31'd4, 32'd3, 31'd4);
        // divide by a zero fraction
        queue_pair(OP_DIV, 32'd3, 31'd4, 32'd0, 31'd5);
        queue_pair(OP_DIV, -32'sd7, 31'd2, -32'sd3, 31'd8);
        // zero denominators in the operands
        queue_pair(OP_ADD, 32'd3, 31'd0, 32'd2, 31'd5);
        queue_pair(OP_MUL, 32'd3, 31'd4, 32'd2, 31'd0);
        queue_pair(OP_DIV, 32'd3, 31'd0, 32'd0, 31'd0);
        // extremes of the fields and most negative magnitudes
        queue_pair(OP_MUL, 32'h8000_0000, 31'd1, 32'd1, 31'd1);
        queue_pair(OP_SUB, 32'd0, 31'd1, 32'h8000_0000, 31'd1);
        queue_pair(OP_ADD, 32'h7FFF_FFFF, 31'h7FFF_FFFF, 32'h7FFF_FFFF, 31'h7FFF_FFFF);
        queue_pair(OP_MUL, 32'd3, 31'h4000_0000, 32'd5, 31'd2);
        queue_pair(OP_DIV, 32'hFFFF_FFFF, 31'h7FFF_FFFF, 32'h8000_0000, 31'h7FFF_FFFF);
        queue_pair(OP_MUL, 32'h7FFF_FFFF, 31'd3, 32'h7FFF_FFFF, 31'd5);
        queue_pair(OP_DIV, 32'd6, 31'd1, 32'hFFFF_FFFF, 31'd1);
        queue_pair(OP_SUB, 32'h5555_5555, 31'h2AAA_AAAA, 32'hAAAA_AAAA, 31'h5555_5555);
        drain();

        // sender idles a little, receiver a lot
        tx_idle_pct = 24;
        rx_idle_pct = 77;
        queue_random(340);
        drain();

        // then the other way round, with one long receiver hold-off
        tx_idle_pct = 77;
        rx_idle_pct = 24;
        hold_req    = hold_req + 1;
        queue_random(340);
        drain();

        // full rate on both sides
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        queue_random(345);
        drain();

        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule

`default_nettype wire

// File: filelist.f
+incdir+rtl
rtl/rau_pkg.sv
rtl/rau_alu.sv
rtl/rau_core.sv
rtl/rational_arithmetic_unit.sv
bench/tb.sv
